[src/uesc_pkg.sv]
// ---------------------------------------------------------------------------
// uesc_pkg
// Shared types, character constants and hex helpers for the unicode
// escape decoder.
// ---------------------------------------------------------------------------
package uesc_pkg;

    localparam int MAX_DIGITS_DEF = 5;   // most hex digits one escape holds
    localparam int MIN_DIGITS     = 4;   // fewest digits that decode
    localparam int QUEUE_DEPTH    = 2;   // command queue entries
    localparam int UNIT_W         = 16;  // result code unit width
    localparam int BYTE_W         = 8;

    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_U         = 8'h75;

    // what the back end has to emit for one input byte, in this order:
    // backslash, 'u', held digits, decoded value, the byte itself
    typedef struct packed {
        logic has_bs;
        logic has_u;
        logic has_val;
        logic has_chr;
    } cmd_ctl_t;

    localparam int CTL_W = $bits(cmd_ctl_t);

    function automatic logic is_hex(input logic [BYTE_W-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] d;
        if (c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c <= 8'h46) begin
            d = c - 8'h37;
        end else begin
            d = c - 8'h57;
        end
        return d[3:0];
    endfunction

endpackage

[src/unicode_escape_decoder.sv]
// A byte's first code unit passes the command queue and then the registered output stage before m_tdata.
// The emitter gives one code unit per cycle while m_tready does not stall it; a byte yields n
// code units, n being its result count (up to MAX_DIGITS + 3 when an overlong escape is flushed).
// The parser takes a byte per cycle while the two-entry command queue has room.
// Reset (aresetn low, synchronous): plain mode, no digits held, queue and output empty;
// the held digit bytes are not cleared.
// ---------------------------------------------------------------------------
// unicode_escape_decoder
// Decodes backslash-u hex escapes in a byte stream into 16-bit code units.
// ---------------------------------------------------------------------------
module unicode_escape_decoder #(
    parameter int MAX_DIGITS = uesc_pkg::MAX_DIGITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_unit
    output logic        m_tlast    // last_of_run
);
    import uesc_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int DIG_W = MAX_DIGITS * 8;
    localparam int Q_W   = DIG_W + CNT_W + UNIT_W + BYTE_W + CTL_W;

    logic             q_full, q_empty;
    logic             push, pop;
    cmd_ctl_t         f_ctl, b_ctl;
    logic [CNT_W-1:0] f_ndig, b_ndig;
    logic [DIG_W-1:0] f_digits, b_digits;
    logic [15:0]      f_val, b_val;
    logic [7:0]       f_chr, b_chr;
    logic [Q_W-1:0]   q_in, q_out;

    uesc_front #(
        .MAX_DIGITS (MAX_DIGITS),
        .CNT_W      (CNT_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .push       (push),
        .cmd_ctl    (f_ctl),
        .cmd_ndig   (f_ndig),
        .cmd_digits (f_digits),
        .cmd_val    (f_val),
        .cmd_chr    (f_chr)
    );

    assign q_in = {f_digits, f_ndig, f_val, f_chr, f_ctl};
    assign {b_digits, b_ndig, b_val, b_chr, b_ctl} = q_out;

    uesc_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (q_in),
        .pop       (pop),
        .pop_data  (q_out),
        .empty     (q_empty),
        .full      (q_full)
    );

    uesc_back #(
        .MAX_DIGITS (MAX_DIGITS),
        .CNT_W      (CNT_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .pop        (pop),
        .cmd_ctl    (b_ctl),
        .cmd_ndig   (b_ndig),
        .cmd_digits (b_digits),
        .cmd_val    (b_val),
        .cmd_chr    (b_chr),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

[src/uesc_front.sv]
// ---------------------------------------------------------------------------
// uesc_front
// Parser: takes one text byte a cycle while the queue has room, tracks
// escape state and held digits, and queues at most one command per byte.
// ---------------------------------------------------------------------------
module uesc_front #(
    parameter int MAX_DIGITS = uesc_pkg::MAX_DIGITS_DEF,
    parameter int CNT_W      = $clog2(MAX_DIGITS + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] text_byte
    input  logic                         s_tlast,   // end_of_message
    input  logic                         q_full,
    output logic                         push,
    output uesc_pkg::cmd_ctl_t           cmd_ctl,
    output logic [CNT_W-1:0]             cmd_ndig,
    output logic [MAX_DIGITS*8-1:0]      cmd_digits,
    output logic [15:0]                  cmd_val,
    output logic [7:0]                   cmd_chr
);
    import uesc_pkg::*;

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    localparam logic [1:0] MODE_PLAIN  = 2'd0;
    localparam logic [1:0] MODE_SLASH  = 2'd1;
    localparam logic [1:0] MODE_ESCAPE = 2'd2;

    logic [1:0]        mode_reg, mode_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [UNIT_W-1:0] val_reg;
    logic [7:0]        store_reg [MAX_DIGITS];
    logic              accept;
    logic              store_we;
    logic              c_hex;
    logic              c_bs;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign c_hex    = is_hex(s_tdata);
    assign c_bs     = (s_tdata == CH_BACKSLASH);
    assign cmd_chr  = s_tdata;
    assign cmd_val  = val_reg;

    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            cmd_digits[i*8 +: 8] = store_reg[i];
        end
    end

    always_comb begin
        cmd_ctl   = '0;
        cmd_ndig  = '0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        store_we  = 1'b0;
        case (mode_reg)
            MODE_SLASH: begin
                if (s_tdata == CH_U) begin
                    mode_next = MODE_ESCAPE;
                    cnt_next  = '0;
                end else begin
                    cmd_ctl.has_bs  = 1'b1;
                    cmd_ctl.has_chr = 1'b1;
                    mode_next       = MODE_PLAIN;
                end
            end
            MODE_ESCAPE: begin
                if (c_hex && cnt_reg < CNT_W'(MAX_DIGITS)) begin
                    store_we = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end else begin
                    cnt_next = '0;
                    if (!c_hex && cnt_reg >= CNT_W'(MIN_DIGITS)) begin
                        cmd_ctl.has_val = 1'b1;
                    end else begin
                        // too short, or one digit too many: give it back literally
                        cmd_ctl.has_bs = 1'b1;
                        cmd_ctl.has_u  = 1'b1;
                        cmd_ndig       = cnt_reg;
                    end
                    if (!c_hex && c_bs) begin
                        mode_next = MODE_SLASH;
                    end else begin
                        cmd_ctl.has_chr = 1'b1;
                        mode_next       = MODE_PLAIN;
                    end
                end
            end
            default: begin
                if (c_bs) begin
                    mode_next = MODE_SLASH;
                end else begin
                    cmd_ctl.has_chr = 1'b1;
                end
            end
        endcase
        if (s_tlast) begin
            mode_next = MODE_PLAIN;
            cnt_next  = '0;
        end
    end

    assign push = accept && (cmd_ctl != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_PLAIN;
            cnt_reg  <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    // only the last four digits survive the 16-bit truncation
    always_ff @(posedge aclk) begin
        if (accept && store_we) begin
            store_reg[cnt_reg[IDX_W-1:0]] <= s_tdata;
            val_reg <= {val_reg[UNIT_W-5:0], hex_val(s_tdata)};
        end
    end

endmodule

[src/uesc_queue.sv]
// ---------------------------------------------------------------------------
// uesc_queue
// Small command queue between the parser and the emitter.
// ---------------------------------------------------------------------------
module uesc_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty,
    output logic             full
);
    import uesc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[src/uesc_back.sv]
// ---------------------------------------------------------------------------
// uesc_back
// Emitter: walks the head command one code unit per cycle, unless m_tready
// stalls, into a registered output stage and pops it with its last unit.
// ---------------------------------------------------------------------------
module uesc_back #(
    parameter int MAX_DIGITS = uesc_pkg::MAX_DIGITS_DEF,
    parameter int CNT_W      = $clog2(MAX_DIGITS + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_empty,
    output logic                    pop,
    input  uesc_pkg::cmd_ctl_t      cmd_ctl,
    input  logic [CNT_W-1:0]        cmd_ndig,
    input  logic [MAX_DIGITS*8-1:0] cmd_digits,
    input  logic [15:0]             cmd_val,
    input  logic [7:0]              cmd_chr,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [15:0]             m_tdata,   // [15:0] code_unit
    output logic                    m_tlast    // last_of_run
);
    import uesc_pkg::*;

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    localparam logic [2:0] PH_BS  = 3'd0;
    localparam logic [2:0] PH_U   = 3'd1;
    localparam logic [2:0] PH_DIG = 3'd2;
    localparam logic [2:0] PH_VAL = 3'd3;
    localparam logic [2:0] PH_CHR = 3'd4;

    logic              m_valid_reg;
    logic [UNIT_W-1:0] data_reg;
    logic              last_reg;
    logic              started_reg;
    logic [2:0]        phase_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic [4:0]        en;
    logic [2:0]        first_ph, cur_ph, nxt_ph;
    logic              more;
    logic              step;
    logic [UNIT_W-1:0] unit;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign step     = !q_empty && (!m_valid_reg || m_tready);
    assign pop      = step && !more;

    always_comb begin
        en = {cmd_ctl.has_chr, cmd_ctl.has_val, (cmd_ndig != '0),
              cmd_ctl.has_u, cmd_ctl.has_bs};
        first_ph = PH_CHR;
        for (int q = 4; q >= 0; q--) begin
            if (en[q]) begin
                first_ph = 3'(q);
            end
        end
        cur_ph = started_reg ? phase_reg : first_ph;

        more   = 1'b0;
        nxt_ph = cur_ph;
        if (cur_ph == PH_DIG && (CNT_W'(idx_reg) + CNT_W'(1) < cmd_ndig)) begin
            more = 1'b1;
        end else begin
            // lowest enabled phase after the current one
            for (int q = 4; q >= 0; q--) begin
                if (3'(q) > cur_ph && en[q]) begin
                    more   = 1'b1;
                    nxt_ph = 3'(q);
                end
            end
        end

        case (cur_ph)
            PH_BS:   unit = {8'h00, CH_BACKSLASH};
            PH_U:    unit = {8'h00, CH_U};
            PH_DIG:  unit = {8'h00, cmd_digits[idx_reg*8 +: 8]};
            PH_VAL:  unit = cmd_val;
            PH_CHR:  unit = {8'h00, cmd_chr};
            default: unit = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            data_reg <= unit;
            last_reg <= !more;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            started_reg <= 1'b0;
            phase_reg   <= PH_BS;
            idx_reg     <= '0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
            if (more) begin
                started_reg <= 1'b1;
                phase_reg   <= nxt_ph;
                idx_reg     <= (cur_ph == PH_DIG && nxt_ph == PH_DIG) ? idx_reg + 1'b1 : '0;
            end else begin
                started_reg <= 1'b0;
                idx_reg     <= '0;
            end
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

endmodule

[tb/tb_unicode_escape_decoder.sv]
// ---------------------------------------------------------------------------
// tb_unicode_escape_decoder
// Drives text bytes into the escape decoder and checks every code unit it
// returns against a cycle-free model of the parser. A short table of
// hand-picked bytes covers plain, backslash, escape, short, overlong and
// end-of-message handling. A long random run of escape sequences and noise
// follows, with random idle bursts on both sides of the block.
// ---------------------------------------------------------------------------
module tb_unicode_escape_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    import uesc_pkg::*;

    localparam int DIGITS      = MAX_DIGITS_DEF;
    localparam int RANDOM_ITEMS = 384;
    localparam int CALM_ITEMS  = 60;
    localparam int CYCLE_LIMIT = 200000;
    localparam int NO_PIN      = -1;

    typedef enum logic [1:0] {
        PM_PLAIN  = 2'd0,
        PM_SLASH  = 2'd1,
        PM_ESCAPE = 2'd2
    } parse_mode_t;

    typedef struct packed {
        logic [15:0] unit;
        logic        last;
    } code_word_t;

    typedef struct {
        logic [7:0]  text;
        logic        eom;
        int          units;   // NO_PIN: left to the model
        logic [15:0] first;
    } byte_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    unicode_escape_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // parser state as the decoder should hold it
    parse_mode_t mode;
    int          held;
    logic [7:0]  digit_bytes [DIGITS];

    code_word_t  pending_words[$];
    logic [15:0] run_units[$];
    int          mismatches = 0;
    int          words_seen = 0;
    int          bytes_sent = 0;
    int          cycles     = 0;
    bit          idle_on    = 1'b1;
    int          stall_left = 0;

    byte_row_t directed_rows [36] = '{
        '{8'h00, 1'b0, 1, 16'h0000},
        '{8'h5C, 1'b0, 0, 16'h0000},
        '{8'hFF, 1'b0, 2, 16'h005C},      // backslash then a plain byte
        '{8'h5C, 1'b0, 0, 16'h0000},
        '{8'h75, 1'b0, 0, 16'h0000},
        '{8'h46, 1'b0, NO_PIN, 16'h0000},
        '{8'h66, 1'b0, NO_PIN, 16'h0000},
        '{8'h30, 1'b0, NO_PIN, 16'h0000},
        '{8'h39, 1'b0, NO_PIN, 16'h0000},
        '{8'h5C, 1'b0, 1, 16'hFF09},      // four digits closed by backslash
        '{8'h75, 1'b0, 0, 16'h0000},
        '{8'h31, 1'b0, NO_PIN, 16'h0000},
        '{8'h32, 1'b0, NO_PIN, 16'h0000},
        '{8'h33, 1'b0, NO_PIN, 16'h0000},
        '{8'h34, 1'b0, NO_PIN, 16'h0000},
        '{8'h35, 1'b0, NO_PIN, 16'h0000},
        '{8'h7A, 1'b0, 2, 16'h2345},      // five digits, truncated to 16 bits
        '{8'h5C, 1'b0, 0, 16'h0000},
        '{8'h75, 1'b0, 0, 16'h0000},
        '{8'h61, 1'b0, NO_PIN, 16'h0000},
        '{8'h62, 1'b0, NO_PIN, 16'h0000},
        '{8'h63, 1'b0, NO_PIN, 16'h0000},
        '{8'h5C, 1'b0, 5, 16'h005C},      // short escape closed by backslash
        '{8'h75, 1'b0, 0, 16'h0000},
        '{8'h47, 1'b0, 3, 16'h005C},      // escape with no digits at all
        '{8'h5C, 1'b0, NO_PIN, 16'h0000},
        '{8'h75, 1'b0, NO_PIN, 16'h0000},
        '{8'h44, 1'b0, NO_PIN, 16'h0000},
        '{8'h45, 1'b0, NO_PIN, 16'h0000},
        '{8'h41, 1'b0, NO_PIN, 16'h0000},
        '{8'h44, 1'b0, NO_PIN, 16'h0000},
        '{8'h30, 1'b0, NO_PIN, 16'h0000},
        '{8'h37, 1'b0, 8, 16'h005C},      // one digit too many
        '{8'h5C, 1'b1, 0, 16'h0000},      // pending backslash dropped
        '{8'h75, 1'b0, 1, 16'h0075},
        '{8'h80, 1'b1, 1, 16'h0080}
    };

    function automatic bit hex_digit(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
               (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] nibble_of(logic [7:0] c);
        // letters of either case carry value - 9 in their low nibble
        if (c <= "9") begin
            return c[3:0];
        end
        return c[3:0] + 4'd9;
    endfunction

    task automatic spill_escape();
        run_units.push_back({8'h00, CH_BACKSLASH});
        run_units.push_back({8'h00, CH_U});
        for (int i = 0; i < held; i++) begin
            run_units.push_back({8'h00, digit_bytes[i]});
        end
        held = 0;
    endtask

    task automatic decode_byte(input logic [7:0] c, input logic eom);
        logic [31:0] acc;
        run_units.delete();
        case (mode)
            PM_SLASH: begin
                if (c == CH_U) begin
                    mode = PM_ESCAPE;
                    held = 0;
                end else begin
                    run_units.push_back({8'h00, CH_BACKSLASH});
                    run_units.push_back({8'h00, c});
                    mode = PM_PLAIN;
                end
            end
            PM_ESCAPE: begin
                if (hex_digit(c)) begin
                    if (held < DIGITS) begin
                        digit_bytes[held] = c;
                        held++;
                    end else begin
                        spill_escape();
                        run_units.push_back({8'h00, c});
                        mode = PM_PLAIN;
                    end
                end else begin
                    if (held >= MIN_DIGITS) begin
                        acc = '0;
                        for (int i = 0; i < held; i++) begin
                            acc = {acc[27:0], nibble_of(digit_bytes[i])};
                        end
                        run_units.push_back(acc[15:0]);
                        held = 0;
                    end else begin
                        spill_escape();
                    end
                    if (c == CH_BACKSLASH) begin
                        mode = PM_SLASH;
                    end else begin
                        run_units.push_back({8'h00, c});
                        mode = PM_PLAIN;
                    end
                end
            end
            default: begin
                if (c == CH_BACKSLASH) begin
                    mode = PM_SLASH;
                end else begin
                    run_units.push_back({8'h00, c});
                end
            end
        endcase
        if (eom) begin
            mode = PM_PLAIN;
            held = 0;
        end
        foreach (run_units[i]) begin
            pending_words.push_back('{unit: run_units[i],
                                      last: (i == run_units.size() - 1)});
        end
    endtask

    task automatic flag(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s", msg);
        end
    endtask

    // one byte over the input channel, predicted once it is taken
    task automatic send_byte(input logic [7:0] c, input logic eom);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eom;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        decode_byte(c, eom);
        bytes_sent++;
    endtask

    task automatic drain_words();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_words.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_hex();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10) begin
            return 8'("0" + v);
        end else if (v < 16) begin
            return 8'("a" + v - 10);
        end
        return 8'("A" + v - 16);
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] v;
        do begin
            v = 8'($urandom_range(0, 255));
        end while (hex_digit(v));
        return v;
    endfunction

    // backslash-u runs with random digit counts, sometimes chained
    task automatic send_escape();
        int         ndig;
        int         r;
        bit         chain;
        logic [7:0] term;
        send_byte(CH_BACKSLASH, 1'b0);
        do begin
            send_byte(CH_U, 1'b0);
            r = $urandom_range(0, 9);
            ndig = (r < 3) ? MIN_DIGITS : (r < 6) ? DIGITS :
                   (r < 8) ? $urandom_range(0, MIN_DIGITS - 1) : DIGITS + 1;
            for (int i = 0; i < ndig; i++) begin
                send_byte(rand_hex(), $urandom_range(0, 39) == 0);
            end
            chain = 1'b0;
            if ($urandom_range(0, 3) == 0) begin
                term  = CH_BACKSLASH;
                chain = 1'($urandom_range(0, 1));
            end else begin
                term = rand_non_hex();
            end
            send_byte(term, !chain && $urandom_range(0, 9) == 0);
        end while (chain);
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_unicode_escape_decoder: errors");
            $finish;
        end
    end

    // receiver with random stall bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_on && aresetn && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 7);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        code_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                flag($sformatf("word %0d: unexpected, code_unit %h last_of_run %b",
                               words_seen, m_tdata, m_tlast));
            end else begin
                want = pending_words.pop_front();
                if (m_tdata !== want.unit) begin
                    flag($sformatf("word %0d: code_unit exp %h got %h",
                                   words_seen, want.unit, m_tdata));
                end
                if (m_tlast !== want.last) begin
                    flag($sformatf("word %0d: last_of_run exp %b got %b",
                                   words_seen, want.last, m_tlast));
                end
            end
            words_seen++;
        end
    end

    initial begin
        int r;
        mode = PM_PLAIN;
        held = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].text, directed_rows[i].eom);
            if (directed_rows[i].units != NO_PIN) begin
                if (run_units.size() != directed_rows[i].units ||
                    (run_units.size() > 0 && run_units[0] !== directed_rows[i].first)) begin
                    flag($sformatf("row %0d: model gives %0d words, pinned %0d first %h",
                                   i, run_units.size(), directed_rows[i].units,
                                   directed_rows[i].first));
                end
            end
        end
        drain_words();

        while (bytes_sent < $size(directed_rows) + RANDOM_ITEMS) begin
            if (bytes_sent > $size(directed_rows) + RANDOM_ITEMS - CALM_ITEMS) begin
                idle_on = 1'b0;
            end
            r = $urandom_range(0, 19);
            if (r < 4) begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else if (r < 16) begin
                send_escape();
            end else if (r < 18) begin
                send_byte(CH_BACKSLASH, 1'b0);
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else begin
                // message ends in the middle of an escape
                send_byte(CH_BACKSLASH, 1'b0);
                send_byte(CH_U, 1'b0);
                send_byte(rand_hex(), 1'b1);
            end
            if ($urandom_range(0, 40) == 0) begin
                drain_words();
            end
        end

        drain_words();
        repeat (16) @(posedge aclk);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("tb_unicode_escape_decoder: clean");
        end else begin
            $display("tb_unicode_escape_decoder: errors");
        end
        $finish;
    end

endmodule
